FILE: hdl/vslpf_pkg.sv
package vslpf_pkg;

  localparam int SAMPLE_W = 32;
  localparam int STAMP_W  = 24;
  localparam int TF_W     = 24;
  localparam int DT_W     = 16;
  localparam int MUL_A_W  = TF_W + 1;
  localparam int PROD_W   = MUL_A_W + SAMPLE_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int DEN_W    = TF_W + 1;
  localparam int QUO_W    = 32;
  localparam int CNT_W    = $clog2(QUO_W);

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;

  localparam logic [TF_W-1:0] TF_RESET        = TF_W'(90000);
  localparam logic [DT_W-1:0] ZERO_STEP_TICKS = DT_W'(13500);
  localparam logic [DT_W-1:0] MAX_STEP_TICKS  = DT_W'(45000);

  localparam logic FUNC_FILTER  = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_TF,
    ST_MUL_DT,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } vslpf_state_t;

  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  dividend;
    logic [DEN_W-1:0]  divisor;
  } vslpf_div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quotient;
  } vslpf_div_rsp_t;

endpackage

FILE: hdl/vslpf_div.sv
module vslpf_div
  import vslpf_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  vslpf_div_req_t req,
  output vslpf_div_rsp_t rsp
);

  // Restoring division, one quotient bit a cycle. The caller guarantees
  // dividend >> QUO_W < divisor, so the quotient fits QUO_W bits.
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;

  always_comb begin
    trial    = {rem_r, quo_r[QUO_W-1]};
    diff     = {1'b0, trial} - {2'b00, req.divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.dividend[QUO_W +: DEN_W];
      quo_nxt  = req.dividend[QUO_W-1:0];
      cnt_nxt  = CNT_W'(QUO_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DEN_W+1]) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: hdl/variable_step_lowpass_filter.sv
// Channel | Handshake            | Payload
// in_     | in_tvalid/in_tready  | tdata: sample[31:0], stamp[55:32]; tuser: func
// out_    | out_tvalid/out_tready| tdata: filtered[31:0]; tuser: passed_through
// cfg_    | cfg_valid/cfg_ready  | cfg_data: tf_ticks
//
// A filtered sample reaches the output register through two passes through the
// one shared 25x32 multiplier, one add, the divider start, the bit-serial
// divider, the quotient pick-up and the output load. Restart and long-step
// items go straight from the idle state to the output state.
// in_tready is high only while the sequencer is idle, so a transaction holds
// the input off until the sequencer returns from the output state, which waits
// while a full result register sees out_tready low.
// The result register lets the next transaction in while a result waits on out_tready.
// Reset (rst_n, synchronous, active low) clears history and sets tf to 90000.
module variable_step_lowpass_filter
  import vslpf_pkg::*;
#(
  parameter int unsigned RELOAD_VALUE = 16777215
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // sample[31:0], stamp[55:32]
  input  logic                   in_tuser,   // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // filtered[31:0]
  output logic                   out_tuser,  // passed_through
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [TF_W-1:0]        cfg_data    // tf_ticks
);

  localparam logic [STAMP_W-1:0] RELOAD = STAMP_W'(RELOAD_VALUE);

  vslpf_state_t state_r, state_nxt;

  logic [TF_W-1:0]     tf_r;
  logic [SAMPLE_W-1:0] last_out_r, last_out_nxt;
  logic [STAMP_W-1:0]  last_stamp_r, last_stamp_nxt;
  logic [SAMPLE_W-1:0] x_r, x_nxt;
  logic [STAMP_W-1:0]  stamp_r, stamp_nxt;
  logic [DT_W-1:0]     dt_r, dt_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [SAMPLE_W-1:0] y_r, y_nxt;
  logic                pt_r, pt_nxt;
  logic                ov_r, ov_nxt;
  logic [SAMPLE_W-1:0] od_r, od_nxt;
  logic                ou_r, ou_nxt;

  // input unpack
  logic                in_acc;
  logic [SAMPLE_W-1:0] in_sample;
  logic [STAMP_W-1:0]  in_stamp;

  // step classification
  logic [STAMP_W+1:0]  wrap_dt;
  logic [STAMP_W:0]    raw_dt;
  logic                wrapped, wrap_neg, step_zero, step_long;

  // shared multiplier
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic signed [PROD_W-1:0]   mul_p;

  logic [ACC_W-1:0]   acc_mag;
  logic [QUO_W-1:0]   quo_signed;
  logic               slot_free;

  vslpf_div_req_t div_req;
  vslpf_div_rsp_t div_rsp;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign in_sample = in_tdata[SAMPLE_W-1:0];
  assign in_stamp  = in_tdata[SAMPLE_W +: STAMP_W];
  assign slot_free = !ov_r || out_tready;

  // Down-counter step; a wrap past a short reload can go negative -> long.
  assign wrapped  = in_stamp > last_stamp_r;
  assign wrap_dt  = {2'b00, last_stamp_r} + {2'b00, RELOAD} - {2'b00, in_stamp};
  assign wrap_neg = wrapped && wrap_dt[STAMP_W+1];
  assign raw_dt   = wrapped ? wrap_dt[STAMP_W:0]
                            : {1'b0, last_stamp_r - in_stamp};
  assign step_zero = !wrap_neg && (raw_dt == '0);
  assign step_long = wrap_neg || (raw_dt > {{(STAMP_W+1-DT_W){1'b0}}, MAX_STEP_TICKS});

  always_comb begin
    if (state_r == ST_MUL_TF) begin
      mul_a = $signed({1'b0, tf_r});
      mul_b = $signed(last_out_r);
    end else begin
      mul_a = $signed({{(MUL_A_W-DT_W){1'b0}}, dt_r});
      mul_b = $signed(x_r);
    end
    mul_p = mul_a * mul_b;
  end

  assign acc_mag    = acc_r[ACC_W-1] ? (~acc_r + 1'b1) : acc_r;
  assign quo_signed = acc_r[ACC_W-1] ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;

  assign div_req.start    = (state_r == ST_DIV_GO);
  assign div_req.dividend = acc_mag;
  assign div_req.divisor  = den_r;

  vslpf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == FUNC_RESTART || step_long) state_nxt = ST_OUT;
          else                                       state_nxt = ST_MUL_TF;
        end
      end
      ST_MUL_TF:   state_nxt = ST_MUL_DT;
      ST_MUL_DT:   state_nxt = ST_ACC;
      ST_ACC:      state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_rsp.done) state_nxt = ST_OUT;
      ST_OUT:      if (slot_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    last_out_nxt   = last_out_r;
    last_stamp_nxt = last_stamp_r;
    x_nxt          = x_r;
    stamp_nxt      = stamp_r;
    dt_nxt         = dt_r;
    den_nxt        = den_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    y_nxt          = y_r;
    pt_nxt         = pt_r;
    ov_nxt         = ov_r && !out_tready;
    od_nxt         = od_r;
    ou_nxt         = ou_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_nxt     = in_sample;
          stamp_nxt = in_stamp;
          dt_nxt    = step_zero ? ZERO_STEP_TICKS : raw_dt[DT_W-1:0];
          if (in_tuser == FUNC_RESTART) begin
            y_nxt  = '0;
            pt_nxt = 1'b0;
          end else begin
            y_nxt  = in_sample;
            pt_nxt = 1'b1;
          end
        end
      end
      ST_MUL_TF: begin
        prod_nxt = mul_p;
        den_nxt  = {1'b0, tf_r} + {{(DEN_W-DT_W){1'b0}}, dt_r};
      end
      ST_MUL_DT: begin
        acc_nxt  = {prod_r[PROD_W-1], prod_r};
        prod_nxt = mul_p;
      end
      ST_ACC: acc_nxt = acc_r + {prod_r[PROD_W-1], prod_r};
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          y_nxt  = quo_signed;
          pt_nxt = 1'b0;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          ov_nxt         = 1'b1;
          od_nxt         = y_r;
          ou_nxt         = pt_r;
          last_out_nxt   = y_r;
          last_stamp_nxt = stamp_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tf_r         <= TF_RESET;
      last_out_r   <= '0;
      last_stamp_r <= '0;
      ov_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_out_r   <= last_out_nxt;
      last_stamp_r <= last_stamp_nxt;
      ov_r         <= ov_nxt;
      if (cfg_valid && cfg_ready) tf_r <= cfg_data;
    end
    x_r     <= x_nxt;
    stamp_r <= stamp_nxt;
    dt_r    <= dt_nxt;
    den_r   <= den_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    y_r     <= y_nxt;
    pt_r    <= pt_nxt;
    od_r    <= od_nxt;
    ou_r    <= ou_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule
